@@ rtl/hte_pkg.sv @@
package hte_pkg;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_FIRST,
		OP_PLAIN0,
		OP_HOLD,
		OP_CUR,
		OP_NL
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic fail;
	} status_t;

	localparam logic [7:0] CH_SP    = 8'd32;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_AMP   = 8'd38;
	localparam logic [7:0] CH_LT    = 8'd60;
	localparam logic [7:0] CH_GT    = 8'd62;
	localparam logic [7:0] CH_SLASH = 8'd47;
	localparam logic [7:0] CH_MIN   = 8'd32;
	localparam logic [7:0] CH_MAX   = 8'd126;
	localparam int unsigned NUM_ENT = 7;
	localparam int unsigned NUM_TAG = 3;

	function automatic logic is_blank(input logic [7:0] c);
		return c == CH_SP || c == CH_TAB || c == CH_CR || c == CH_LF;
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
	endfunction

	function automatic logic [2:0] tag_len(input logic [1:0] k);
		case (k)
			2'd0:    return 3'd5;
			2'd1:    return 3'd6;
			default: return 3'd4;
		endcase
	endfunction

	function automatic logic [47:0] tag_text(input logic [1:0] k);
		case (k)
			2'd0:    return 48'("style");
			2'd1:    return 48'("script");
			default: return 48'("head");
		endcase
	endfunction

	function automatic logic [7:0] tag_char(input logic [1:0] k, input logic [2:0] pos);
		logic [47:0] w;
		logic [2:0]  sh;
		w  = tag_text(k);
		sh = tag_len(k) - 3'd1 - pos;
		return w[{sh, 3'b000} +: 8];
	endfunction

	function automatic logic [2:0] ent_len(input logic [2:0] k);
		case (k)
			3'd0, 3'd1, 3'd5: return 3'd6;
			3'd2, 3'd6:       return 3'd5;
			default:          return 3'd4;
		endcase
	endfunction

	function automatic logic [47:0] ent_text(input logic [2:0] k);
		case (k)
			3'd0:    return 48'("&nbsp;");
			3'd1:    return 48'("&#160;");
			3'd2:    return 48'("&amp;");
			3'd3:    return 48'("&lt;");
			3'd4:    return 48'("&gt;");
			3'd5:    return 48'("&quot;");
			default: return 48'("&#39;");
		endcase
	endfunction

	function automatic logic [7:0] ent_value(input logic [2:0] k);
		case (k)
			3'd0, 3'd1: return 8'd32;
			3'd2:       return 8'd38;
			3'd3:       return 8'd60;
			3'd4:       return 8'd62;
			3'd5:       return 8'd34;
			default:    return 8'd39;
		endcase
	endfunction

	function automatic logic [7:0] ent_char(input logic [2:0] k, input logic [2:0] pos);
		logic [47:0] w;
		logic [2:0]  sh;
		w  = ent_text(k);
		sh = ent_len(k) - 3'd1 - pos;
		return w[{sh, 3'b000} +: 8];
	endfunction

endpackage

@@ rtl/html_text_extractor.sv @@
// Extracts the visible text of an HTML body, one input byte per request. Tags are dropped and
// a tag close yields one space unless one was just sent; style, script and head sections are
// suppressed; the entities &nbsp; &#160; &amp; &lt; &gt; &quot; &#39; are decoded; blank runs
// collapse to one space. An input byte with tlast ends the document with a newline carrying
// tlast and resets all state. A byte is taken only while the control is idle and the output
// register is free to take its result. A byte that breaks a partial entity replays the held
// bytes one per cycle, while the output register is free, through the same byte handler and
// then handles the breaking byte; a final byte is followed by a check for a held entity, the
// replay of any bytes still held and then the newline.
module html_text_extractor import hte_pkg::*; #(
	parameter int unsigned ENTITY_HOLD_DEPTH = 6
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] in_byte
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,  // [7:0] out_byte
	output logic       m_tlast
);

	localparam int unsigned CW = $clog2(ENTITY_HOLD_DEPTH + 1);
	localparam int unsigned IW = $clog2(ENTITY_HOLD_DEPTH);

	cmd_t cmd;
	status_t status;
	logic [IW-1:0] idx;
	logic [CW-1:0] count;

	hte_control #(.ENTITY_HOLD_DEPTH(ENTITY_HOLD_DEPTH)) u_control (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.s_tlast(s_tlast), .cmd(cmd), .idx(idx), .status(status), .count(count)
	);

	hte_datapath #(.ENTITY_HOLD_DEPTH(ENTITY_HOLD_DEPTH)) u_datapath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .idx(idx), .status(status), .count(count),
		.in_byte(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

endmodule

@@ rtl/hte_datapath.sv @@
module hte_datapath import hte_pkg::*; #(
	parameter int unsigned ENTITY_HOLD_DEPTH = 6
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  cmd_t                                   cmd,
	input  logic [$clog2(ENTITY_HOLD_DEPTH)-1:0]   idx,
	output status_t                                status,
	output logic [$clog2(ENTITY_HOLD_DEPTH+1)-1:0] count,
	input  logic [7:0]                             in_byte,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [7:0]                             m_tdata,
	output logic                                   m_tlast
);

	localparam int unsigned CW = $clog2(ENTITY_HOLD_DEPTH + 1);
	localparam int unsigned IW = $clog2(ENTITY_HOLD_DEPTH);

	logic [7:0] hold_q [ENTITY_HOLD_DEPTH];
	logic [7:0] cur_q;
	logic [CW-1:0] ecount_q, ecount_n;
	logic [NUM_ENT-1:0] ecand_q, ecand_n;
	logic inside_q, inside_n, space_q, space_n, closing_q, closing_n;
	logic hstyle_q, hstyle_n, hscript_q, hscript_n, hhead_q, hhead_n;
	logic [1:0] phase_q, phase_n;
	logic [2:0] npos_q, npos_n;
	logic [NUM_TAG-1:0] tcand_q, tcand_n;
	logic out_valid_q, out_last_q;
	logic [7:0] out_byte_q;

	logic out_free;
	logic emit, emit_last, do_handle, do_plain, do_name, frozen, full, prefix, fail;
	logic hold_we;
	logic [IW-1:0] hold_wa;
	logic [7:0] c, pc, eb, ev;
	logic [2:0] pos3;
	logic [NUM_TAG-1:0] keep;
	logic hit_found;
	logic [1:0] hit;

	assign out_free = !out_valid_q || m_tready;
	assign status.out_free = out_free;
	assign status.fail = fail;
	assign count = ecount_q;
	assign m_tvalid = out_valid_q;
	assign m_tdata = out_byte_q;
	assign m_tlast = out_last_q;
	assign pos3 = 3'(ecount_q);

	always_comb begin
		ecount_n = ecount_q; ecand_n = ecand_q; inside_n = inside_q; space_n = space_q;
		closing_n = closing_q; hstyle_n = hstyle_q; hscript_n = hscript_q; hhead_n = hhead_q;
		phase_n = phase_q; npos_n = npos_q; tcand_n = tcand_q;
		emit = 1'b0; emit_last = 1'b0; eb = CH_SP; do_handle = 1'b0; do_plain = 1'b0;
		do_name = 1'b0; frozen = 1'b0; full = 1'b0; prefix = 1'b0; fail = 1'b0;
		hold_we = 1'b0; hold_wa = '0; keep = '0; hit_found = 1'b0; hit = '0; ev = CH_SP;
		c = in_byte; pc = in_byte;
		unique case (cmd.op)
			OP_FIRST: begin
				c = in_byte;
				if (ecount_q != '0) begin
					ecand_n = '0;
					for (int k = NUM_ENT - 1; k >= 0; k--) begin
						if (ecand_q[k] && pos3 < ent_len(3'(k)) && ecount_q <= CW'(5)
								&& ent_char(3'(k), pos3) == c) begin
							ecand_n[k] = 1'b1;
							if (pos3 + 3'd1 == ent_len(3'(k))) begin
								full = 1'b1;
								ev = ent_value(3'(k));
							end else begin
								prefix = 1'b1;
							end
						end
					end
					if (full) begin
						ecount_n = '0;
						do_plain = 1'b1;
						pc = ev;
					end else if (prefix) begin
						hold_we = 1'b1;
						hold_wa = ecount_q[IW-1:0];
						ecount_n = ecount_q + CW'(1);
					end else begin
						fail = 1'b1;
					end
				end else begin
					do_handle = 1'b1;
				end
			end
			OP_PLAIN0: begin
				ecount_n = '0;
				do_plain = 1'b1;
				pc = hold_q[0];
			end
			OP_HOLD: begin
				c = hold_q[idx];
				do_handle = 1'b1;
			end
			OP_CUR: begin
				c = cur_q;
				ecount_n = '0;
				do_handle = 1'b1;
			end
			OP_NL: begin
				emit = 1'b1; emit_last = 1'b1; eb = CH_LF;
				inside_n = 1'b0; space_n = 1'b1; hstyle_n = 1'b0; hscript_n = 1'b0;
				hhead_n = 1'b0; phase_n = '0; closing_n = 1'b0; npos_n = '0;
				tcand_n = '1; ecount_n = '0;
			end
			default: ;
		endcase

		if (do_handle) begin
			if (inside_q) begin
				if (c == CH_GT) begin
					for (int k = NUM_TAG - 1; k >= 0; k--) begin
						if (tcand_q[k] && (phase_q == 2'd3
								|| (phase_q == 2'd2 && npos_q == tag_len(2'(k))))) begin
							hit_found = 1'b1;
							hit = 2'(k);
						end
					end
					if (hit_found) begin
						case (hit)
							2'd0:    hstyle_n = !closing_q;
							2'd1:    hscript_n = !closing_q;
							default: hhead_n = !closing_q;
						endcase
					end
					inside_n = 1'b0; phase_n = '0; closing_n = 1'b0; npos_n = '0; tcand_n = '1;
					if (!space_q) begin
						emit = 1'b1; eb = CH_SP; space_n = 1'b1;
					end
				end else if (phase_q == 2'd0) begin
					if (!is_blank(c)) begin
						if (c == CH_SLASH) begin
							closing_n = 1'b1; phase_n = 2'd1;
						end else begin
							phase_n = 2'd2; do_name = 1'b1;
						end
					end
				end else if (phase_q == 2'd1) begin
					if (!is_blank(c)) begin
						phase_n = 2'd2; do_name = 1'b1;
					end
				end else if (phase_q == 2'd2) begin
					do_name = 1'b1;
				end
			end else if (c == CH_LT) begin
				inside_n = 1'b1; phase_n = '0; closing_n = 1'b0; npos_n = '0; tcand_n = '1;
			end else if (!(hstyle_q || hscript_q || hhead_q)) begin
				if (c == CH_AMP) begin
					hold_we = 1'b1; hold_wa = '0; ecount_n = CW'(1); ecand_n = '1;
				end else begin
					do_plain = 1'b1; pc = c;
				end
			end
		end

		if (do_name) begin
			for (int k = 0; k < NUM_TAG; k++) begin
				if (tcand_q[k]) begin
					if (npos_q < tag_len(2'(k))) begin
						if (to_lower(c) == tag_char(2'(k), npos_q)) keep[k] = 1'b1;
					end else if (npos_q == tag_len(2'(k)) && (is_blank(c) || c == CH_SLASH)) begin
						keep[k] = 1'b1;
						frozen = 1'b1;
					end
				end
			end
			tcand_n = keep;
			if (frozen) phase_n = 2'd3;
			else if (npos_q != 3'd7) npos_n = npos_q + 3'd1;
		end

		if (do_plain && pc != CH_CR) begin
			if (pc == CH_LF || pc == CH_TAB || pc == CH_SP) begin
				if (!space_q) begin
					emit = 1'b1; eb = CH_SP; space_n = 1'b1;
				end
			end else if (pc >= CH_MIN && pc <= CH_MAX) begin
				emit = 1'b1; eb = pc; space_n = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ecount_q <= '0; ecand_q <= '1; inside_q <= 1'b0; space_q <= 1'b1;
			closing_q <= 1'b0; hstyle_q <= 1'b0; hscript_q <= 1'b0; hhead_q <= 1'b0;
			phase_q <= '0; npos_q <= '0; tcand_q <= '1; out_valid_q <= 1'b0;
		end else begin
			ecount_q <= ecount_n; ecand_q <= ecand_n; inside_q <= inside_n; space_q <= space_n;
			closing_q <= closing_n; hstyle_q <= hstyle_n; hscript_q <= hscript_n;
			hhead_q <= hhead_n; phase_q <= phase_n; npos_q <= npos_n; tcand_q <= tcand_n;
			if (emit) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= eb;
			out_last_q <= emit_last;
		end
		if (cmd.op == OP_FIRST) cur_q <= in_byte;
		if (hold_we) hold_q[hold_wa] <= c;
	end

endmodule

@@ rtl/hte_control.sv @@
module hte_control import hte_pkg::*; #(
	parameter int unsigned ENTITY_HOLD_DEPTH = 6
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic                                   s_tlast,
	output cmd_t                                   cmd,
	output logic [$clog2(ENTITY_HOLD_DEPTH)-1:0]   idx,
	input  status_t                                status,
	input  logic [$clog2(ENTITY_HOLD_DEPTH+1)-1:0] count
);

	localparam int unsigned CW = $clog2(ENTITY_HOLD_DEPTH + 1);
	localparam int unsigned IW = $clog2(ENTITY_HOLD_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_REP0,
		S_REP,
		S_CUR,
		S_FLCHK,
		S_NL
	} state_t;

	state_t state_q;
	logic [CW-1:0] n_q, i_q;
	logic last_q, flush_q;

	assign s_tready = state_q == S_IDLE && status.out_free;
	assign idx = i_q[IW-1:0];

	always_comb begin
		cmd.op = OP_NONE;
		unique case (state_q)
			S_IDLE:  if (s_tvalid && status.out_free) cmd.op = OP_FIRST;
			S_REP0:  if (status.out_free) cmd.op = OP_PLAIN0;
			S_REP:   if (status.out_free) cmd.op = OP_HOLD;
			S_CUR:   if (status.out_free) cmd.op = OP_CUR;
			S_NL:    if (status.out_free) cmd.op = OP_NL;
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q <= '0;
			i_q <= '0;
			last_q <= 1'b0;
			flush_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid && status.out_free) begin
						last_q <= s_tlast;
						flush_q <= 1'b0;
						if (status.fail) begin
							n_q <= count;
							state_q <= S_REP0;
						end else if (s_tlast) begin
							state_q <= S_FLCHK;
						end
					end
				end
				S_REP0: begin
					if (status.out_free) begin
						i_q <= CW'(1);
						if (n_q > CW'(1)) state_q <= S_REP;
						else state_q <= flush_q ? S_NL : S_CUR;
					end
				end
				S_REP: begin
					if (status.out_free) begin
						i_q <= i_q + CW'(1);
						if (i_q == n_q - CW'(1)) state_q <= flush_q ? S_NL : S_CUR;
					end
				end
				S_CUR: begin
					if (status.out_free) state_q <= last_q ? S_FLCHK : S_IDLE;
				end
				S_FLCHK: begin
					if (count != '0) begin
						n_q <= count;
						flush_q <= 1'b1;
						state_q <= S_REP0;
					end else begin
						state_q <= S_NL;
					end
				end
				S_NL: begin
					if (status.out_free) begin
						flush_q <= 1'b0;
						last_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ bench/tb_html_text_extractor.sv @@
`timescale 1ns / 100ps

module tb_html_text_extractor import hte_pkg::*;;

	typedef struct {
		logic [7:0] text;
		logic       eod;
	} text_byte_t;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       s_tlast;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	logic       m_tlast;

	text_byte_t expected_text[$];
	int         error_count;
	bit         src_idle_en;
	bit         sink_idle_en;

	// Shadow copy of the extractor state.
	bit         in_tag;
	bit         blank_sent;
	bit         hid_style;
	bit         hid_script;
	bit         hid_head;
	logic [2:0] phase;
	bit         closing;
	logic [2:0] name_pos;
	logic [2:0] live_names;
	logic [7:0] held[6];
	int         held_count;

	string ent_str[7] = '{"&nbsp;", "&#160;", "&amp;", "&lt;", "&gt;", "&quot;", "&#39;"};
	byte   ent_val[7] = '{8'd32, 8'd32, 8'd38, 8'd60, 8'd62, 8'd34, 8'd39};
	string tag_str[3] = '{"style", "script", "head"};

	html_text_extractor u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit blank_char(logic [7:0] c);
		return c == CH_SP || c == CH_TAB || c == CH_CR || c == CH_LF;
	endfunction

	function automatic logic [7:0] lower_char(logic [7:0] c);
		return (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
	endfunction

	function automatic void shadow_reset();
		in_tag = 0; blank_sent = 1;
		hid_style = 0; hid_script = 0; hid_head = 0;
		phase = 0; closing = 0; name_pos = 0; live_names = 3'd7;
		held_count = 0;
	endfunction

	function automatic void expect_text(logic [7:0] c, logic e);
		text_byte_t t;
		t.text = c;
		t.eod  = e;
		expected_text.push_back(t);
	endfunction

	function automatic void show_plain(logic [7:0] c);
		if (c == CH_CR)
			return;
		if (c == CH_LF || c == CH_TAB || c == CH_SP) begin
			if (!blank_sent) begin
				expect_text(CH_SP, 0);
				blank_sent = 1;
			end
			return;
		end
		if (c < CH_MIN || c > CH_MAX)
			return;
		expect_text(c, 0);
		blank_sent = 0;
	endfunction

	function automatic void match_name(logic [7:0] c);
		logic [2:0] keep;
		bit         frozen;
		keep = 0;
		frozen = 0;
		for (int k = 0; k < 3; k++) begin
			if (!live_names[k])
				continue;
			if (name_pos < tag_str[k].len()) begin
				if (lower_char(c) == tag_str[k][name_pos])
					keep[k] = 1;
			end else if (name_pos == tag_str[k].len() && (blank_char(c) || c == CH_SLASH)) begin
				keep[k] = 1;
				frozen = 1;
			end
		end
		live_names = keep;
		if (frozen)
			phase = 3;
		else if (name_pos < 7)
			name_pos++;
	endfunction

	function automatic void close_tag();
		int hit;
		hit = -1;
		for (int k = 0; k < 3; k++) begin
			if (live_names[k] && (phase == 3 || (phase == 2 && name_pos == tag_str[k].len()))) begin
				hit = k;
				break;
			end
		end
		if (hit == 0)
			hid_style = !closing;
		else if (hit == 1)
			hid_script = !closing;
		else if (hit == 2)
			hid_head = !closing;
		in_tag = 0;
		phase = 0; closing = 0; name_pos = 0; live_names = 3'd7;
		if (!blank_sent) begin
			expect_text(CH_SP, 0);
			blank_sent = 1;
		end
	endfunction

	function automatic void take_char(logic [7:0] c);
		if (in_tag) begin
			if (c == CH_GT) begin
				close_tag();
				return;
			end
			if (phase == 0) begin
				if (blank_char(c))
					return;
				if (c == CH_SLASH) begin
					closing = 1;
					phase = 1;
					return;
				end
				phase = 2;
				match_name(c);
			end else if (phase == 1) begin
				if (blank_char(c))
					return;
				phase = 2;
				match_name(c);
			end else if (phase == 2) begin
				match_name(c);
			end
			return;
		end
		if (c == CH_LT) begin
			in_tag = 1;
			phase = 0; closing = 0; name_pos = 0; live_names = 3'd7;
			return;
		end
		if (hid_style || hid_script || hid_head)
			return;
		if (c == CH_AMP) begin
			held[0] = CH_AMP;
			held_count = 1;
			return;
		end
		show_plain(c);
	endfunction

	function automatic void replay_entity();
		int n;
		n = held_count;
		held_count = 0;
		if (n == 0)
			return;
		show_plain(held[0]);
		for (int i = 1; i < n; i++)
			take_char(held[i]);
	endfunction

	function automatic void predict_text(logic [7:0] c, logic eod);
		if (held_count > 0) begin
			int  n;
			int  full;
			bit  prefix;
			bit  same;
			n = held_count + 1;
			full = -1;
			prefix = 0;
			for (int k = 0; k < 7; k++) begin
				if (n > ent_str[k].len())
					continue;
				same = 1;
				for (int i = 0; i < n; i++)
					if (((i < held_count) ? held[i] : c) != ent_str[k][i])
						same = 0;
				if (same) begin
					if (n == ent_str[k].len()) begin
						full = k;
						break;
					end
					prefix = 1;
				end
			end
			if (full >= 0) begin
				held_count = 0;
				show_plain(ent_val[full]);
			end else if (prefix && n <= 6) begin
				held[held_count] = c;
				held_count = n;
			end else begin
				replay_entity();
				take_char(c);
			end
		end else begin
			take_char(c);
		end
		if (eod) begin
			replay_entity();
			expect_text(CH_LF, 1);
			shadow_reset();
		end
	endfunction

	task automatic send_byte(logic [7:0] c, logic eod);
		if (src_idle_en && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= eod;
		predict_text(c, eod);
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic send_string(string s, bit eod);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], eod && i == s.len() - 1);
	endtask

	task automatic test_directed();
		send_string("<P>Hi \t\r\nthere&amp;&lt;&gt;&quot;&#39;&nbsp;&#160;x", 0);
		send_string("&am;&#16 >a<STYLE>zz</ style><ScRiPt/>q</script>", 0);
		send_string("<head >h</head><styles>v", 1);
		send_byte(8'h00, 0);
		send_byte(8'hFF, 0);
		send_string("&lt", 1);
	endtask

	function automatic string rand_piece();
		string s;
		case ($urandom_range(0, 9))
			0: s = ent_str[$urandom_range(0, 6)];
			1: begin
				s = ent_str[$urandom_range(0, 6)];
				s = s.substr(0, $urandom_range(0, s.len() - 2));
			end
			2: begin
				if ($urandom_range(0, 1))
					s = "</ ";
				else
					s = "< ";
				s = {s, tag_str[$urandom_range(0, 2)], ">"};
			end
			3: s = {"<", tag_str[$urandom_range(0, 2)], "x>"};
			4: s = "<div class=a>";
			5: s = " \t\n";
			default: begin
				s = "";
				repeat ($urandom_range(1, 4))
					s = {s, string'(byte'($urandom_range(0, 255)))};
			end
		endcase
		return s;
	endfunction

	task automatic test_random(int count);
		string s;
		int    sent;
		sent = 0;
		while (sent < count) begin
			s = rand_piece();
			for (int i = 0; i < s.len(); i++) begin
				send_byte(s[i], $urandom_range(0, 40) == 0);
				sent++;
			end
		end
		send_byte(8'h2E, 1);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_text.size() == 0) begin
				$display("%0t: unexpected output byte %h last %b", $time, m_tdata, m_tlast);
				error_count++;
			end else begin
				text_byte_t t;
				t = expected_text.pop_front();
				if (t.text !== m_tdata || t.eod !== m_tlast) begin
					$display("%0t: expected byte %h last %b, got byte %h last %b",
						$time, t.text, t.eod, m_tdata, m_tlast);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (sink_idle_en && $urandom_range(0, 7) == 0) begin
			m_tready <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		m_tready <= 1'b1;
	end

	initial begin
		error_count = 0;
		src_idle_en = 1;
		sink_idle_en = 1;
		s_tvalid = 0;
		s_tdata = 0;
		s_tlast = 0;
		m_tready = 0;
		arst_n = 0;
		shadow_reset();
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_random(230);
		src_idle_en = 0;
		sink_idle_en = 0;
		test_random(60);
		s_tvalid <= 1'b0;
		while (expected_text.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
